// ===== rtl/gbn_pkg.sv =====
// Shared constants and types of the go-back-N window endpoint.
package gbn_pkg;

   localparam int SEQ_BITS_DEF     = 3;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [1:0] {
      EV_NEW     = 2'd0,
      EV_FRAME   = 2'd1,
      EV_CKERR   = 2'd2,
      EV_TIMEOUT = 2'd3
   } ev_kind_type;

   typedef enum logic [1:0] {
      RSP_SEND   = 2'd0,
      RSP_DELIV  = 2'd1,
      RSP_STOP   = 2'd2,
      RSP_STATUS = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic valid;
   } ev_hs_type;

endpackage

// ===== rtl/gbn_front.sv =====
// Event intake: accepts request beats, merges the payload fields and queues events.
module gbn_front #(
   parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  gbn_pkg::ev_kind_type     req_kind,
   input  logic [PAYLOAD_BITS-1:0]  req_packet_in,
   input  logic [SEQ_BITS-1:0]      req_rx_seq,
   input  logic [SEQ_BITS-1:0]      req_rx_ack,
   input  logic [PAYLOAD_BITS-1:0]  req_rx_info,
   input  logic                     ev_pop,
   output logic                     ev_valid,
   output gbn_pkg::ev_kind_type     ev_kind,
   output logic [SEQ_BITS-1:0]      ev_seq,
   output logic [SEQ_BITS-1:0]      ev_ack,
   output logic [PAYLOAD_BITS-1:0]  ev_payload
);

   localparam int EV_W  = 2 + 2 * SEQ_BITS + PAYLOAD_BITS;
   localparam int PTR_W = $clog2(gbn_pkg::QUEUE_DEPTH);

   logic [EV_W-1:0]  q_ff [gbn_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push;
   logic [PAYLOAD_BITS-1:0] merged;
   logic [EV_W-1:0]  head;

   // only a new packet carries the network-layer payload, every other kind the frame's
   assign merged     = (req_kind == gbn_pkg::EV_NEW) ? req_packet_in : req_rx_info;
   assign req_tready = (count_ff != (PTR_W + 1)'(gbn_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   assign head       = q_ff[rd_ptr_ff];
   assign ev_valid   = (count_ff != '0);
   assign ev_kind    = gbn_pkg::ev_kind_type'(head[EV_W-1 -: 2]);
   assign ev_seq     = head[PAYLOAD_BITS + 2 * SEQ_BITS - 1 -: SEQ_BITS];
   assign ev_ack     = head[PAYLOAD_BITS + SEQ_BITS - 1 -: SEQ_BITS];
   assign ev_payload = head[PAYLOAD_BITS-1:0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? PTR_W'(1) : PTR_W'(0));
      rd_ptr_in = rd_ptr_ff + (ev_pop ? PTR_W'(1) : PTR_W'(0));
      count_in  = count_ff;
      if (push && !ev_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && ev_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= {req_kind, req_rx_seq, req_rx_ack, merged};
      end
   end

endmodule

// ===== rtl/gbn_engine.sv =====
// Window sequencer: owns the window state and send store and emits result beats.
module gbn_engine #(
   parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gbn_pkg::ev_hs_type       ev_hs_in,
   output logic                     ev_pop,
   input  gbn_pkg::ev_kind_type     ev_kind,
   input  logic [SEQ_BITS-1:0]      ev_seq,
   input  logic [SEQ_BITS-1:0]      ev_ack,
   input  logic [PAYLOAD_BITS-1:0]  ev_payload,
   input  logic                     rsp_tready,
   output logic                     rsp_valid,
   output gbn_pkg::rsp_kind_type    rsp_kind,
   output logic [SEQ_BITS-1:0]      rsp_seq,
   output logic [SEQ_BITS-1:0]      rsp_ack,
   output logic [PAYLOAD_BITS-1:0]  rsp_payload,
   output logic                     rsp_net_enable,
   output logic                     rsp_dropped,
   output logic                     rsp_last
);

   localparam int DEPTH = 1 << SEQ_BITS;
   localparam logic [SEQ_BITS-1:0] MAX_SEQ = '1;
   localparam logic [SEQ_BITS-1:0] ONE     = SEQ_BITS'(1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEND   = 6'b000010,
      ST_DELIV  = 6'b000100,
      ST_STOP   = 6'b001000,
      ST_RESEND = 6'b010000,
      ST_STATUS = 6'b100000
   } eng_state_type;

   eng_state_type state_ff, state_in;
   logic [SEQ_BITS-1:0] next_send_ff, next_send_in;
   logic [SEQ_BITS-1:0] oldest_ff, oldest_in;
   logic [SEQ_BITS-1:0] expected_ff, expected_in;
   logic [SEQ_BITS-1:0] outstanding_ff, outstanding_in;
   logic [SEQ_BITS-1:0] ptr_ff, ptr_in;
   logic [SEQ_BITS-1:0] cnt_ff, cnt_in;
   logic [SEQ_BITS-1:0] rack_ff, rack_in;
   logic [PAYLOAD_BITS-1:0] info_ff, info_in;
   logic drop_ff, drop_in;

   logic [PAYLOAD_BITS-1:0] store [DEPTH];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic store_we;

   logic rsp_valid_ff;
   gbn_pkg::rsp_kind_type rsp_kind_ff, e_kind;
   logic [SEQ_BITS-1:0] rsp_seq_ff, rsp_ack_ff, e_seq, e_ack;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff, e_payload;
   logic rsp_en_ff, rsp_drop_ff, rsp_last_ff, e_en, e_drop, e_last;
   logic emit, emit_ok;
   logic [SEQ_BITS-1:0] ack_val;
   logic acked;

   // b lies in [a, c) in circular order
   function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                      input logic [SEQ_BITS-1:0] b,
                                      input logic [SEQ_BITS-1:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction

   assign emit_ok = !rsp_valid_ff || rsp_tready;
   assign ack_val = expected_ff + MAX_SEQ;
   assign acked   = (outstanding_ff != '0) && in_window(oldest_ff, rack_ff, next_send_ff);

   always_comb begin
      state_in       = state_ff;
      next_send_in   = next_send_ff;
      oldest_in      = oldest_ff;
      expected_in    = expected_ff;
      outstanding_in = outstanding_ff;
      ptr_in         = ptr_ff;
      cnt_in         = cnt_ff;
      rack_in        = rack_ff;
      info_in        = info_ff;
      drop_in        = drop_ff;
      store_we       = 1'b0;
      ev_pop         = 1'b0;
      emit           = 1'b0;
      e_kind         = gbn_pkg::RSP_STATUS;
      e_seq          = '0;
      e_ack          = '0;
      e_payload      = '0;
      e_en           = 1'b0;
      e_drop         = 1'b0;
      e_last         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ev_hs_in.valid) begin
               ev_pop  = 1'b1;
               info_in = ev_payload;
               rack_in = ev_ack;
               drop_in = 1'b0;
               unique case (ev_kind)
                  gbn_pkg::EV_NEW: begin
                     if (outstanding_ff == MAX_SEQ) begin
                        drop_in  = 1'b1;
                        state_in = ST_STATUS;
                     end else begin
                        store_we       = 1'b1;
                        ptr_in         = next_send_ff;
                        next_send_in   = next_send_ff + ONE;
                        outstanding_in = outstanding_ff + ONE;
                        state_in       = ST_SEND;
                     end
                  end
                  gbn_pkg::EV_FRAME: begin
                     if (ev_seq == expected_ff) begin
                        expected_in = expected_ff + ONE;
                        state_in    = ST_DELIV;
                     end else begin
                        state_in = ST_STOP;
                     end
                  end
                  gbn_pkg::EV_CKERR: begin
                     state_in = ST_STATUS;
                  end
                  gbn_pkg::EV_TIMEOUT: begin
                     if (outstanding_ff != '0) begin
                        ptr_in   = oldest_ff;
                        cnt_in   = outstanding_ff;
                        state_in = ST_RESEND;
                     end else begin
                        state_in = ST_STATUS;
                     end
                  end
                  default: state_in = ST_STATUS;
               endcase
            end
         end
         ST_SEND: begin
            if (emit_ok) begin
               emit      = 1'b1;
               e_kind    = gbn_pkg::RSP_SEND;
               e_seq     = ptr_ff;
               e_ack     = ack_val;
               e_payload = info_ff;
               state_in  = ST_STATUS;
            end
         end
         ST_DELIV: begin
            if (emit_ok) begin
               emit      = 1'b1;
               e_kind    = gbn_pkg::RSP_DELIV;
               e_payload = info_ff;
               state_in  = ST_STOP;
            end
         end
         ST_STOP: begin
            if (!acked) begin
               state_in = ST_STATUS;
            end else if (emit_ok) begin
               emit           = 1'b1;
               e_kind         = gbn_pkg::RSP_STOP;
               e_seq          = oldest_ff;
               oldest_in      = oldest_ff + ONE;
               outstanding_in = outstanding_ff - ONE;
            end
         end
         ST_RESEND: begin
            if (emit_ok) begin
               emit      = 1'b1;
               e_kind    = gbn_pkg::RSP_SEND;
               e_seq     = ptr_ff;
               e_ack     = ack_val;
               e_payload = rd_data_ff;
               ptr_in    = ptr_ff + ONE;
               cnt_in    = cnt_ff - ONE;
               if (cnt_ff == ONE) begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_STATUS: begin
            if (emit_ok) begin
               emit     = 1'b1;
               e_kind   = gbn_pkg::RSP_STATUS;
               e_en     = (outstanding_ff != MAX_SEQ);
               e_drop   = drop_ff;
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_send_ff   <= '0;
         oldest_ff      <= '0;
         expected_ff    <= '0;
         outstanding_ff <= '0;
         cnt_ff         <= '0;
         drop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_send_ff   <= next_send_in;
         oldest_ff      <= oldest_in;
         expected_ff    <= expected_in;
         outstanding_ff <= outstanding_in;
         cnt_ff         <= cnt_in;
         drop_ff        <= drop_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      rack_ff <= rack_in;
      info_ff <= info_in;
      if (emit) begin
         rsp_kind_ff    <= e_kind;
         rsp_seq_ff     <= e_seq;
         rsp_ack_ff     <= e_ack;
         rsp_payload_ff <= e_payload;
         rsp_en_ff      <= e_en;
         rsp_drop_ff    <= e_drop;
         rsp_last_ff    <= e_last;
      end
   end

   // read port follows the next pointer; rd_data_ff holds pre-write store[ptr_ff]
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[next_send_ff] <= ev_payload;
      end
      rd_data_ff <= store[ptr_in];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_seq        = rsp_seq_ff;
   assign rsp_ack        = rsp_ack_ff;
   assign rsp_payload    = rsp_payload_ff;
   assign rsp_net_enable = rsp_en_ff;
   assign rsp_dropped    = rsp_drop_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   logic [SEQ_BITS-1:0] window_end;
   assign window_end = oldest_ff + outstanding_ff;

   a_window_sum: assert property (@(posedge clock) disable iff (reset)
      next_send_ff == window_end)
      else $error("window bounds and outstanding count disagree");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result beat overwritten before it was taken");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      ev_pop |-> (ev_hs_in.valid && state_ff == ST_IDLE))
      else $error("event popped outside idle or from an empty queue");

   a_resend_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESEND) |-> (cnt_ff != '0))
      else $error("resend walk with nothing left to send");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == ST_STATUS) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("status beat not marked last");
`endif

endmodule

// ===== rtl/go_back_n_sliding_window.sv =====
// Top level of the go-back-N sliding-window endpoint.
//
//   channel  direction  tdata (low bit up)                          tuser     tlast
//   req      in         packet_in, rx_seq, rx_ack, rx_info, pad     kind      -
//   rsp      out        seq_out, ack_out, payload_out, net_enable,  out_kind  last
//                       dropped, pad
//
// An event leaves the queue in the idle state, then the window-walk sequencer in gbn_engine
// emits its result beats, stalling while the output is held; a frame arrival adds a
// closing window check.
// Reset clears the window counters, queue and output register; the send store
// comes up unknown and needs no clearing pass.
// The event queue holds two events, so intake runs on while the output is stalled until it fills.
module go_back_n_sliding_window #(
   parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF,
   localparam int REQ_W = ((2 * PAYLOAD_BITS + 2 * SEQ_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((PAYLOAD_BITS + 2 * SEQ_BITS + 2 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // packet_in, rx_seq, rx_ack, rx_info, zero pad
   input  logic [1:0]       req_tuser,   // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // seq_out, ack_out, payload_out, net_enable,
                                         // dropped, zero pad
   output logic [1:0]       rsp_tuser,   // out_kind
   output logic             rsp_tlast
);

   gbn_pkg::ev_kind_type    ev_kind;
   gbn_pkg::ev_hs_type      ev_hs;
   gbn_pkg::rsp_kind_type   rsp_kind;
   logic                    ev_valid, ev_pop;
   logic [SEQ_BITS-1:0]     ev_seq, ev_ack, rsp_seq, rsp_ack;
   logic [PAYLOAD_BITS-1:0] ev_payload, rsp_payload;
   logic                    rsp_net_enable, rsp_dropped;

   gbn_front #(
      .SEQ_BITS     (SEQ_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_kind      (gbn_pkg::ev_kind_type'(req_tuser)),
      .req_packet_in (req_tdata[PAYLOAD_BITS-1:0]),
      .req_rx_seq    (req_tdata[PAYLOAD_BITS +: SEQ_BITS]),
      .req_rx_ack    (req_tdata[PAYLOAD_BITS + SEQ_BITS +: SEQ_BITS]),
      .req_rx_info   (req_tdata[PAYLOAD_BITS + 2 * SEQ_BITS +: PAYLOAD_BITS]),
      .ev_pop        (ev_pop),
      .ev_valid      (ev_valid),
      .ev_kind       (ev_kind),
      .ev_seq        (ev_seq),
      .ev_ack        (ev_ack),
      .ev_payload    (ev_payload)
   );

   assign ev_hs.valid = ev_valid;

   gbn_engine #(
      .SEQ_BITS     (SEQ_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .ev_hs_in       (ev_hs),
      .ev_pop         (ev_pop),
      .ev_kind        (ev_kind),
      .ev_seq         (ev_seq),
      .ev_ack         (ev_ack),
      .ev_payload     (ev_payload),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_kind       (rsp_kind),
      .rsp_seq        (rsp_seq),
      .rsp_ack        (rsp_ack),
      .rsp_payload    (rsp_payload),
      .rsp_net_enable (rsp_net_enable),
      .rsp_dropped    (rsp_dropped),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({rsp_dropped, rsp_net_enable, rsp_payload, rsp_ack, rsp_seq});
   assign rsp_tuser = rsp_kind;

endmodule

// ===== dv/gbn_checker.sv =====
// Scoreboard for the go-back-N endpoint: predicts the result beats of each event and compares.
module gbn_checker #(
   parameter int REQ_W = 72,
   parameter int RSP_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic [1:0]       rsp_tuser,
   input  logic             rsp_tlast,
   output int               failures,
   output int               pending,
   output int               beats_seen,
   output int               drops_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEQ_W  = gbn_pkg::SEQ_BITS_DEF;
   localparam int PAY_W  = gbn_pkg::PAYLOAD_BITS_DEF;
   localparam int WINDOW = (1 << SEQ_W) - 1;

   typedef struct {
      gbn_pkg::rsp_kind_type kind;
      logic [SEQ_W-1:0]      seq;
      logic [SEQ_W-1:0]      ack;
      logic [PAY_W-1:0]      pay;
      logic                  net_en;
      logic                  refused;
      logic                  last;
   } rsp_beat_type;

   rsp_beat_type     due_beats[$];
   logic [SEQ_W-1:0] tx_next;
   logic [SEQ_W-1:0] tx_base;
   logic [SEQ_W-1:0] rx_expect;
   int               in_flight;
   logic [PAY_W-1:0] sent_payload[1 << SEQ_W];

   task automatic flag(string msg);
      failures++;
      if (failures <= 40) $display("ERROR %0t: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
      if (got !== want)
         flag($sformatf("beat %0d: %s is 0x%0h, want 0x%0h", beats_seen, name, got, want));
   endtask

   task automatic queue_beat(gbn_pkg::rsp_kind_type kind, logic [SEQ_W-1:0] seq,
                             logic [SEQ_W-1:0] ack, logic [PAY_W-1:0] pay, logic net_en,
                             logic refused, logic last);
      rsp_beat_type b;
      b.kind    = kind;
      b.seq     = seq;
      b.ack     = ack;
      b.pay     = pay;
      b.net_en  = net_en;
      b.refused = refused;
      b.last    = last;
      due_beats.push_back(b);
   endtask

   // Advance the window for one event and queue every beat it produces.
   task automatic advance_window(gbn_pkg::ev_kind_type kind, logic [PAY_W-1:0] packet,
                                 logic [SEQ_W-1:0] rseq, logic [SEQ_W-1:0] rack,
                                 logic [PAY_W-1:0] info);
      logic refused;
      int   n;
      refused = 1'b0;
      case (kind)
         gbn_pkg::EV_NEW: begin
            if (in_flight >= WINDOW) begin
               refused = 1'b1;
            end else begin
               sent_payload[tx_next] = packet;
               in_flight++;
               queue_beat(gbn_pkg::RSP_SEND, tx_next, SEQ_W'(rx_expect - 1'b1), packet,
                          0, 0, 0);
               tx_next = SEQ_W'(tx_next + 1'b1);
            end
         end
         gbn_pkg::EV_FRAME: begin
            if (rseq == rx_expect) begin
               queue_beat(gbn_pkg::RSP_DELIV, '0, '0, info, 0, 0, 0);
               rx_expect = SEQ_W'(rx_expect + 1'b1);
            end
            // free frames up to and including the ack, if it lies inside the window
            while (in_flight != 0 && SEQ_W'(rack - tx_base) < SEQ_W'(tx_next - tx_base)) begin
               in_flight--;
               queue_beat(gbn_pkg::RSP_STOP, tx_base, '0, '0, 0, 0, 0);
               tx_base = SEQ_W'(tx_base + 1'b1);
            end
         end
         gbn_pkg::EV_TIMEOUT: begin
            tx_next = tx_base;
            for (n = 0; n < in_flight; n++) begin
               queue_beat(gbn_pkg::RSP_SEND, tx_next, SEQ_W'(rx_expect - 1'b1),
                          sent_payload[tx_next], 0, 0, 0);
               tx_next = SEQ_W'(tx_next + 1'b1);
            end
         end
         default: ;
      endcase
      queue_beat(gbn_pkg::RSP_STATUS, '0, '0, '0, in_flight < WINDOW, refused, 1'b1);
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         due_beats.delete();
         tx_next    = '0;
         tx_base    = '0;
         rx_expect  = '0;
         in_flight  = 0;
         failures   = 0;
         beats_seen = 0;
         drops_seen = 0;
      end else begin
         if (req_tvalid && req_tready)
            advance_window(gbn_pkg::ev_kind_type'(req_tuser), req_tdata[PAY_W-1:0],
                           req_tdata[PAY_W +: SEQ_W], req_tdata[PAY_W+SEQ_W +: SEQ_W],
                           req_tdata[PAY_W+2*SEQ_W +: PAY_W]);
         if (rsp_tvalid && rsp_tready) begin
            if (due_beats.size() == 0) begin
               flag($sformatf("beat %0d arrived with nothing expected", beats_seen));
            end else begin
               want = due_beats.pop_front();
               check_field("out_kind", rsp_tuser, want.kind);
               check_field("seq_out", rsp_tdata[SEQ_W-1:0], want.seq);
               check_field("ack_out", rsp_tdata[SEQ_W +: SEQ_W], want.ack);
               check_field("payload_out", rsp_tdata[2*SEQ_W +: PAY_W], want.pay);
               check_field("net_enable", rsp_tdata[2*SEQ_W+PAY_W], want.net_en);
               check_field("dropped", rsp_tdata[2*SEQ_W+PAY_W+1], want.refused);
               check_field("last", rsp_tlast, want.last);
               if (want.refused) drops_seen++;
            end
            beats_seen++;
         end
      end
      pending <= due_beats.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the go-back-N endpoint bench: clock, reset, event stimulus, back-pressure and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEQ_W = gbn_pkg::SEQ_BITS_DEF;
   localparam int PAY_W = gbn_pkg::PAYLOAD_BITS_DEF;
   localparam int REQ_W = ((2 * PAY_W + 2 * SEQ_W + 7) / 8) * 8;
   localparam int RSP_W = ((PAY_W + 2 * SEQ_W + 2 + 7) / 8) * 8;
   localparam int WINDOW = (1 << SEQ_W) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // packet_in, rx_seq, rx_ack, rx_info, zero pad
   logic [1:0]       req_tuser = '0;   // kind
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // seq_out, ack_out, payload_out, net_enable, dropped
   logic [1:0]       rsp_tuser;        // out_kind
   logic             rsp_tlast;

   int failures;
   int pending;
   int beats_seen;
   int drops_seen;

   // stimulus-side view of the far end: next frame number to send, and the window to ack
   logic [SEQ_W-1:0] peer_seq = '0;
   logic [SEQ_W-1:0] win_base = '0;
   int               win_count = 0;
   int               burst_left = 1;
   int               gap_max = 3;
   int               events_of_kind[4] = '{default: 0};
   bit               hold_off = 1'b0;
   bit               rx_steady = 1'b0;
   logic [15:0]      ready_pattern;
   int               pattern_left = 0;

   go_back_n_sliding_window dut (.*);

   gbn_checker #(.REQ_W(REQ_W), .RSP_W(RSP_W)) scoreboard (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** go_back_n_sliding_window: FAILED **");
      $finish;
   end

   // Receiver: rotate a random ready pattern, or hold off for a long stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            hold_off = 1'b0;
            repeat (80) @(posedge clock);
         end else begin
            if (pattern_left == 0) begin
               ready_pattern = rx_steady ? '1 : 16'($urandom);
               pattern_left  = 16;
            end
            rsp_tready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_left--;
         end
      end
   end

   task automatic offer(gbn_pkg::ev_kind_type kind, logic [PAY_W-1:0] packet,
                        logic [SEQ_W-1:0] rseq, logic [SEQ_W-1:0] rack,
                        logic [PAY_W-1:0] info);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_W'({info, rack, rseq, packet});
      do @(posedge clock); while (!req_tready);
      events_of_kind[kind]++;
      if (kind == gbn_pkg::EV_NEW && win_count < WINDOW) win_count++;
      if (kind == gbn_pkg::EV_FRAME) begin
         if (rseq == peer_seq) peer_seq = SEQ_W'(peer_seq + 1'b1);
         if (int'(SEQ_W'(rack - win_base)) < win_count) begin
            win_count -= int'(SEQ_W'(rack - win_base)) + 1;
            win_base   = SEQ_W'(rack + 1'b1);
         end
      end
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 8);
         gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // In-order frame whose ack lands inside the outstanding window when one is open.
   task automatic frame_in_order();
      logic [SEQ_W-1:0] rack;
      rack = (win_count > 0) ? SEQ_W'(win_base + $urandom_range(0, win_count - 1))
                             : SEQ_W'($urandom);
      offer(gbn_pkg::EV_FRAME, $urandom, peer_seq, rack, $urandom);
   endtask

   task automatic random_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         offer(gbn_pkg::EV_NEW, $urandom, SEQ_W'($urandom), SEQ_W'($urandom), $urandom);
      else if (pick < 80)
         frame_in_order();
      else if (pick < 88)
         offer(gbn_pkg::EV_TIMEOUT, $urandom, SEQ_W'($urandom), SEQ_W'($urandom), $urandom);
      else if (pick < 93)
         offer(gbn_pkg::EV_CKERR, $urandom, SEQ_W'($urandom), SEQ_W'($urandom), $urandom);
      else
         offer(gbn_pkg::EV_FRAME, $urandom, SEQ_W'(peer_seq + $urandom_range(1, WINDOW)),
               SEQ_W'($urandom), $urandom);
   endtask

   // Hold off the sender until every expected beat has come back.
   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-window events, a full window, a refusal, a full resend and a full ack
      offer(gbn_pkg::EV_TIMEOUT, $urandom, SEQ_W'($urandom), SEQ_W'($urandom), $urandom);
      offer(gbn_pkg::EV_CKERR, $urandom, SEQ_W'($urandom), SEQ_W'($urandom), $urandom);
      offer(gbn_pkg::EV_FRAME, $urandom, SEQ_W'(peer_seq + 3), 3'd5, $urandom);
      offer(gbn_pkg::EV_NEW, '0, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, '1, '1, '1, '1);
      offer(gbn_pkg::EV_NEW, 32'hAAAA_AAAA, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, 32'h5555_5555, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, 32'h0000_0001, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, 32'h8000_0000, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, $urandom, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, $urandom, '0, '0, '0);
      offer(gbn_pkg::EV_TIMEOUT, '0, '0, '0, '0);
      offer(gbn_pkg::EV_FRAME, $urandom, peer_seq, 3'd6, '1);
      offer(gbn_pkg::EV_FRAME, $urandom, 3'd7, 3'd7, '0);
      offer(gbn_pkg::EV_NEW, $urandom, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, $urandom, '0, '0, '0);
      offer(gbn_pkg::EV_NEW, $urandom, '0, '0, '0);
      offer(gbn_pkg::EV_FRAME, $urandom, peer_seq, 3'd7, $urandom);
      offer(gbn_pkg::EV_FRAME, $urandom, SEQ_W'(peer_seq + 2), 3'd3, $urandom);
      offer(gbn_pkg::EV_TIMEOUT, '1, '1, '1, '1);
      drain();

      // random: bursty sender, then back to back with a steady receiver
      gap_max = 4;
      repeat (25) random_event();
      gap_max   = 0;
      rx_steady = 1'b1;
      repeat (25) random_event();
      drain();

      // long receiver stall while the sender keeps offering, so intake backs up
      rx_steady = 1'b0;
      hold_off  = 1'b1;
      repeat (25) random_event();
      gap_max = 6;
      repeat (25) random_event();
      drain();
      repeat (20) @(posedge clock);

      $display("Ran %0d events: %0d new packet, %0d frame arrival, %0d checksum error,",
               events_of_kind[gbn_pkg::EV_NEW] + events_of_kind[gbn_pkg::EV_FRAME]
               + events_of_kind[gbn_pkg::EV_CKERR] + events_of_kind[gbn_pkg::EV_TIMEOUT],
               events_of_kind[gbn_pkg::EV_NEW], events_of_kind[gbn_pkg::EV_FRAME],
               events_of_kind[gbn_pkg::EV_CKERR]);
      $display("%0d timeout; checked %0d result beats, %0d refusals with the window full",
               events_of_kind[gbn_pkg::EV_TIMEOUT], beats_seen, drops_seen);
      if (failures == 0)
         $display("** go_back_n_sliding_window: PASSED **");
      else
         $display("** go_back_n_sliding_window: FAILED **");
      $finish;
   end

endmodule
